/* hw/rtl/spbt_pkg.sv */
// Shared types and constants for the sensor packet bit transmitter.
// No dependencies; every other file refers to this package by scoped names.
package spbt_pkg;

    localparam int unsigned TempW   = 16;
    localparam int unsigned DevIdW  = 32;
    localparam int unsigned SensTW  = 8;
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned CfgDatW = 32;

    // idle gap lasts GapTicks + 1 ticks
    localparam logic [7:0] GapTicks = 8'd64;

    localparam logic [SensTW-1:0] SensorTypeRst = 8'h02;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgDeviceId   = 8'd0;
    localparam logic [CfgIdxW-1:0] CfgSensorType = 8'd1;

    typedef struct packed {
        logic [DevIdW-1:0] device_id;
        logic [SensTW-1:0] sensor_type;
    } t_cfg;

    typedef struct packed {
        logic line_level;
        logic in_gap;
    } t_step_res;

endpackage

/* hw/rtl/spbt_if.sv */
// Handshake channel interfaces: request input, result output, configuration write.
// Depends on spbt_pkg for widths.
interface spbt_req_if;
    logic                          valid;
    logic                          ready;
    logic signed [spbt_pkg::TempW-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

interface spbt_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic in_gap;

    modport source (output valid, output line_level, output in_gap, input ready);
    modport sink   (input valid, input line_level, input in_gap, output ready);
endinterface

interface spbt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [spbt_pkg::CfgIdxW-1:0]  index;
    logic [spbt_pkg::CfgDatW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/sensor_packet_bit_transmitter_core.sv */
// Sensor packet bit transmitter, one bit-time tick per request.
// The request is held in the input register and advances into the result register
// once the result slot is free or draining; the receiver then takes the result.
// Throughput: 1 request per cycle while the result receiver applies no backpressure.
// Reset (synchronous, active low): line idles high, sequencer at start bit,
// device id 0, sensor type 2, both stages empty.
module sensor_packet_bit_transmitter_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spbt_req_if.sink      i_req,
    spbt_cfg_if.sink      i_cfg,
    spbt_res_if.source    o_res
);

    logic                         r_in_vld;
    logic [spbt_pkg::TempW-1:0]   r_in_temp;
    logic                         r_out_vld;
    logic                         r_out_line;
    logic                         r_out_gap;
    logic                         adv;
    spbt_pkg::t_cfg               cfg;
    spbt_pkg::t_step_res          step_res;

    // advance the held request whenever the result slot is free or draining
    assign adv         = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || adv;

    spbt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    spbt_fsm u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (adv),
        .i_temperature (r_in_temp),
        .i_cfg         (cfg),
        .o_res         (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_vld <= i_req.valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_temp <= i_req.temperature;
        end
        if (adv) begin
            r_out_line <= step_res.line_level;
            r_out_gap  <= step_res.in_gap;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.line_level = r_out_line;
    assign o_res.in_gap     = r_out_gap;

    a_gap_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_gap |-> r_out_line)
        else $error("idle gap tick with line low");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("advanced request left no result");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !r_out_vld |-> adv)
        else $error("request held while result slot empty");

endmodule

/* hw/rtl/spbt_cfg.sv */
// Configuration registers: device id and sensor type.
// Depends on spbt_pkg and spbt_cfg_if.
module spbt_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spbt_cfg_if.sink          i_cfg,
    output spbt_pkg::t_cfg    o_cfg
);

    logic [spbt_pkg::DevIdW-1:0] r_device_id;
    logic [spbt_pkg::SensTW-1:0] r_sensor_type;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id   <= '0;
            r_sensor_type <= spbt_pkg::SensorTypeRst;
        end else if (i_cfg.valid) begin
            // drop writes to unknown indexes
            case (i_cfg.index)
                spbt_pkg::CfgDeviceId:   r_device_id   <= i_cfg.data;
                spbt_pkg::CfgSensorType: r_sensor_type <= i_cfg.data[spbt_pkg::SensTW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.device_id   = r_device_id;
    assign o_cfg.sensor_type = r_sensor_type;

endmodule

/* hw/rtl/spbt_fsm.sv */
// Packet sequencer: phase, bit/byte counters, latched temperature, checksum, line.
// Depends on spbt_pkg (config and result structs, gap length).
module spbt_fsm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [spbt_pkg::TempW-1:0]        i_temperature,
    input  spbt_pkg::t_cfg                    i_cfg,
    output spbt_pkg::t_step_res               o_res
);

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_DATA    = 3'd1,
        PH_STOP    = 3'd3,
        PH_WAIT    = 3'd4,
        PH_RS_HIGH = 3'd5,
        PH_RS_LOW  = 3'd6
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [2:0]   r_bit_idx, n_bit_idx;
    logic [2:0]   r_byte_idx, n_byte_idx;
    logic [7:0]   r_gap_cnt, n_gap_cnt;
    logic [15:0]  r_latched, n_latched;
    logic [7:0]   r_sum, n_sum;
    logic         r_line, n_line;
    logic         gap;
    logic [7:0]   cur_byte;
    logic [7:0]   start_sum;
    logic [7:0]   gap_inc;

    // byte currently on the wire
    always_comb begin
        case (r_byte_idx)
            3'd0:    cur_byte = i_cfg.device_id[31:24];
            3'd1:    cur_byte = i_cfg.device_id[23:16];
            3'd2:    cur_byte = i_cfg.device_id[15:8];
            3'd3:    cur_byte = i_cfg.device_id[7:0];
            3'd4:    cur_byte = i_cfg.sensor_type;
            3'd5:    cur_byte = r_latched[15:8];
            3'd6:    cur_byte = r_latched[7:0];
            default: cur_byte = r_sum;
        endcase
    end

    // checksum over bytes 0-6 with the freshly latched temperature
    assign start_sum = ((i_cfg.device_id[31:24] + i_cfg.device_id[23:16])
                      + (i_cfg.device_id[15:8] + i_cfg.device_id[7:0]))
                     + ((i_cfg.sensor_type + i_temperature[15:8]) + i_temperature[7:0]);

    assign gap_inc = r_gap_cnt + 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_bit_idx  = r_bit_idx;
        n_byte_idx = r_byte_idx;
        n_gap_cnt  = r_gap_cnt;
        n_latched  = r_latched;
        n_sum      = r_sum;
        n_line     = r_line;
        gap        = 1'b0;
        case (r_phase)
            PH_START: begin
                n_line     = 1'b0;
                n_bit_idx  = '0;
                n_byte_idx = '0;
                n_latched  = i_temperature;
                n_sum      = start_sum;
                n_phase    = PH_DATA;
            end
            PH_DATA: begin
                n_line    = cur_byte[3'd7 - r_bit_idx];
                n_bit_idx = r_bit_idx + 3'd1;
                if (r_bit_idx == 3'd7) begin
                    n_byte_idx = r_byte_idx + 3'd1;
                    // no resync pair after the checksum byte
                    n_phase    = (r_byte_idx == 3'd7) ? PH_STOP : PH_RS_HIGH;
                end
            end
            PH_RS_HIGH: begin
                n_line  = 1'b1;
                n_phase = PH_RS_LOW;
            end
            PH_RS_LOW: begin
                n_line  = 1'b0;
                n_phase = PH_DATA;
            end
            PH_STOP: begin
                n_line    = 1'b1;
                n_gap_cnt = '0;
                n_phase   = PH_WAIT;
            end
            PH_WAIT: begin
                gap       = 1'b1;
                n_gap_cnt = gap_inc;
                if (gap_inc > spbt_pkg::GapTicks) begin
                    n_phase = PH_START;
                end
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_bit_idx  <= '0;
            r_byte_idx <= '0;
            r_gap_cnt  <= '0;
            r_latched  <= '0;
            r_sum      <= '0;
            r_line     <= 1'b1;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_bit_idx  <= n_bit_idx;
            r_byte_idx <= n_byte_idx;
            r_gap_cnt  <= n_gap_cnt;
            r_latched  <= n_latched;
            r_sum      <= n_sum;
            r_line     <= n_line;
        end
    end

    assign o_res.line_level = n_line;
    assign o_res.in_gap     = gap;

endmodule

/* dv/sensor_packet_bit_transmitter_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sensor_packet_bit_transmitter_core: tick requests in,
// line level and gap flag out, register writes between phases. Needs spbt_pkg, spbt_if.
module sensor_packet_bit_transmitter_core_tb;

    localparam int unsigned IdleLimit = 2000;
    localparam int unsigned DirRows   = 25;

    typedef enum logic [2:0] {
        SeqStart  = 3'd0,
        SeqData   = 3'd1,
        SeqStop   = 3'd3,
        SeqWait   = 3'd4,
        SeqRsHigh = 3'd5,
        SeqRsLow  = 3'd6
    } t_seq_phase;

    typedef struct packed {
        logic signed [spbt_pkg::TempW-1:0] temp;
        logic                              typed;
        spbt_pkg::t_step_res               want;
    } t_tick_row;

    logic i_clk;
    logic i_rst_n;

    spbt_req_if req_ch ();
    spbt_cfg_if cfg_ch ();
    spbt_res_if res_ch ();

    sensor_packet_bit_transmitter_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // transmitter shadow state
    logic [spbt_pkg::DevIdW-1:0] dev_id;
    logic [spbt_pkg::SensTW-1:0] sens_type;
    t_seq_phase        seq_ph;
    logic [3:0]        bit_cnt;
    logic [3:0]        byte_cnt;
    logic [7:0]        gap_cnt;
    logic [15:0]       temp_hold;
    logic [7:0]        csum;
    logic              line_now;

    spbt_pkg::t_step_res pending_levels [$];
    int unsigned mismatches;
    int unsigned idle_cycles;
    bit          req_quiet;
    bit          res_quiet;
    t_tick_row   dir_rows [DirRows];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [7:0] packet_byte_at(input logic [3:0] idx);
        case (idx[2:0])
            3'd0:    return dev_id[31:24];
            3'd1:    return dev_id[23:16];
            3'd2:    return dev_id[15:8];
            3'd3:    return dev_id[7:0];
            3'd4:    return sens_type;
            3'd5:    return temp_hold[15:8];
            3'd6:    return temp_hold[7:0];
            default: return csum;
        endcase
    endfunction

    task automatic predict_tick(input logic signed [spbt_pkg::TempW-1:0] t,
                                output spbt_pkg::t_step_res r);
        logic       gap;
        logic [7:0] s;
        logic [7:0] b;
        gap = 1'b0;
        case (seq_ph)
            SeqStart: begin
                line_now  = 1'b0;
                bit_cnt   = '0;
                byte_cnt  = '0;
                seq_ph    = SeqData;
                temp_hold = t;
                s = '0;
                for (int i = 0; i < 7; i++) begin
                    s = s + packet_byte_at(i[3:0]);
                end
                csum = s;
            end
            SeqData: begin
                b        = packet_byte_at(byte_cnt);
                line_now = b[3'd7 - bit_cnt[2:0]];
                bit_cnt  = bit_cnt + 4'd1;
                if (bit_cnt > 4'd7) begin
                    bit_cnt  = '0;
                    byte_cnt = byte_cnt + 4'd1;
                    seq_ph   = SeqRsHigh;
                end
                // last byte skips the resync pair
                if (byte_cnt > 4'd7) begin
                    byte_cnt = byte_cnt + 4'd1;
                    seq_ph   = SeqStop;
                end
            end
            SeqRsHigh: begin
                line_now = 1'b1;
                seq_ph   = SeqRsLow;
            end
            SeqRsLow: begin
                line_now = 1'b0;
                seq_ph   = SeqData;
            end
            SeqStop: begin
                line_now = 1'b1;
                seq_ph   = SeqWait;
                gap_cnt  = '0;
            end
            SeqWait: begin
                gap     = 1'b1;
                gap_cnt = gap_cnt + 8'd1;
                if (gap_cnt > spbt_pkg::GapTicks) seq_ph = SeqStart;
            end
            default: seq_ph = SeqStart;
        endcase
        r.line_level = line_now;
        r.in_gap     = gap;
    endtask

    task automatic send_tick(input logic signed [spbt_pkg::TempW-1:0] t,
                             input logic typed, input spbt_pkg::t_step_res want);
        int unsigned         wait_cyc;
        spbt_pkg::t_step_res got;
        wait_cyc = req_quiet ? 0 : $urandom_range(0, 10);
        if (wait_cyc != 0) begin
            req_ch.valid <= 1'b0;
            repeat (wait_cyc) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.temperature <= t;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_tick(t, got);
        pending_levels.push_back(typed ? want : got);
        if ($urandom_range(0, 31) == 0) req_quiet = !req_quiet;
    endtask

    // valid stays high across back-to-back writes; caller drops it
    task automatic write_reg(input logic [spbt_pkg::CfgIdxW-1:0] idx,
                             input logic [spbt_pkg::CfgDatW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == spbt_pkg::CfgDeviceId) dev_id = val;
        else if (idx == spbt_pkg::CfgSensorType) sens_type = val[spbt_pkg::SensTW-1:0];
    endtask

    task automatic drain_results;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        spbt_pkg::t_step_res exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_levels.size() == 0) begin
                $display("%0t: unexpected result line_level=%0b in_gap=%0b",
                         $time, res_ch.line_level, res_ch.in_gap);
                mismatches++;
            end else begin
                exp_r = pending_levels.pop_front();
                if (res_ch.line_level !== exp_r.line_level) begin
                    $display("%0t: line_level expected %0b actual %0b",
                             $time, exp_r.line_level, res_ch.line_level);
                    mismatches++;
                end
                if (res_ch.in_gap !== exp_r.in_gap) begin
                    $display("%0t: in_gap expected %0b actual %0b",
                             $time, exp_r.in_gap, res_ch.in_gap);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result receiver with random backpressure
    initial begin
        int unsigned stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = res_quiet ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            if ($urandom_range(0, 31) == 0) res_quiet = !res_quiet;
        end
    end

    initial begin
        int unsigned                       n_items;
        logic signed [spbt_pkg::TempW-1:0] t;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.temperature = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        mismatches         = 0;
        idle_cycles        = 0;
        req_quiet          = 1'b0;
        res_quiet          = 1'b0;
        dev_id             = '0;
        sens_type          = spbt_pkg::SensorTypeRst;
        seq_ph             = SeqStart;
        bit_cnt            = '0;
        byte_cnt           = '0;
        gap_cnt            = '0;
        temp_hold          = '0;
        csum               = '0;
        line_now           = 1'b1;

        // after reset: start bit, then byte 0 of a zero id, then the resync pair
        dir_rows = '{
            '{16'sh7FFF, 1'b1, 2'b00}, '{16'sh8000, 1'b1, 2'b00},
            '{16'sh0000, 1'b1, 2'b00}, '{16'shFFFF, 1'b1, 2'b00},
            '{16'sh5555, 1'b1, 2'b00}, '{16'shAAAA, 1'b1, 2'b00},
            '{16'sh0001, 1'b1, 2'b00}, '{16'sh8001, 1'b1, 2'b00},
            '{16'sh7FFE, 1'b1, 2'b00}, '{16'sh1234, 1'b1, 2'b10},
            '{16'shFEDC, 1'b1, 2'b00}, '{16'sh8000, 1'b0, 2'b00},
            '{16'sh7FFF, 1'b0, 2'b00}, '{16'sh0000, 1'b0, 2'b00},
            '{16'shFFFF, 1'b0, 2'b00}, '{16'sh00FF, 1'b0, 2'b00},
            '{16'shFF00, 1'b0, 2'b00}, '{16'sh0F0F, 1'b0, 2'b00},
            '{16'shF0F0, 1'b0, 2'b00}, '{16'sh3C3C, 1'b0, 2'b00},
            '{16'shC3C3, 1'b0, 2'b00}, '{16'sh8000, 1'b0, 2'b00},
            '{16'sh7FFF, 1'b0, 2'b00}, '{16'sh0000, 1'b0, 2'b00},
            '{16'shFFFF, 1'b0, 2'b00}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_tick(dir_rows[k].temp, dir_rows[k].typed, dir_rows[k].want);
        end

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                req_ch.valid <= 1'b0;
                drain_results();
                case (p)
                    1: begin
                        write_reg(spbt_pkg::CfgDeviceId, 32'hFFFF_FFFF);
                        write_reg(spbt_pkg::CfgSensorType, 32'h0000_00FF);
                    end
                    2: begin
                        write_reg(spbt_pkg::CfgSensorType, 32'h0000_0000);
                        write_reg(spbt_pkg::CfgDeviceId, 32'h0000_0000);
                        write_reg(spbt_pkg::CfgIdxW'($urandom_range(2, 255)), $urandom);
                    end
                    3: begin
                        // upper data bits must not reach the type byte
                        write_reg(spbt_pkg::CfgSensorType, $urandom);
                        write_reg(spbt_pkg::CfgDeviceId, $urandom);
                    end
                    4: begin
                        write_reg(spbt_pkg::CfgIdxW'($urandom_range(2, 255)), $urandom);
                        write_reg(spbt_pkg::CfgDeviceId, $urandom);
                    end
                    default: begin
                        write_reg(spbt_pkg::CfgDeviceId, $urandom);
                        write_reg(spbt_pkg::CfgSensorType, {24'h0, 8'($urandom)});
                        write_reg(spbt_pkg::CfgIdxW'($urandom_range(2, 255)), $urandom);
                    end
                endcase
                cfg_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            n_items = $urandom_range(90, 130);
            repeat (n_items) begin
                // bias the latched value toward its extremes at the start bit
                if (seq_ph == SeqStart && $urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 3))
                        0:       t = 16'sh8000;
                        1:       t = 16'sh7FFF;
                        2:       t = 16'sh0000;
                        default: t = 16'shFFFF;
                    endcase
                end else begin
                    t = spbt_pkg::TempW'($urandom);
                end
                send_tick(t, 1'b0, 2'b00);
            end
        end

        req_ch.valid <= 1'b0;
        drain_results();
        repeat (4) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/spbt_pkg.sv
hw/rtl/spbt_if.sv
hw/rtl/spbt_cfg.sv
hw/rtl/spbt_fsm.sv
hw/rtl/sensor_packet_bit_transmitter_core.sv
dv/sensor_packet_bit_transmitter_core_tb.sv
